// ----- hw/rtl/wpc_pkg.sv -----
// Shared types and constants for the WAV PCM16 chunk parser.
package wpc_pkg;

   localparam logic [31:0] RIFF_ID = 32'h5249_4646;
   localparam logic [31:0] WAVE_ID = 32'h5741_5645;
   localparam logic [31:0] FMT_ID  = 32'h666D_7420;
   localparam logic [31:0] DATA_ID = 32'h6461_7461;

   localparam logic [31:0] FMT_BODY_LEN = 32'd16;
   localparam logic [15:0] PCM_FORMAT   = 16'd1;
   localparam logic [15:0] MONO         = 16'd1;
   localparam logic [15:0] PCM_BITS     = 16'd16;

   localparam int RESULT_DEPTH = 4;
   localparam int PTR_W        = $clog2(RESULT_DEPTH);
   localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_BAD_ID      = 3'd0,
      ERR_FMT_SMALL   = 3'd1,
      ERR_NO_FMT      = 3'd2,
      ERR_UNSUPPORTED = 3'd3,
      ERR_ODD_DATA    = 3'd4,
      ERR_TRUNCATED   = 3'd5
   } err_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] sample;
      logic [31:0]        rate;
      logic [15:0]        channel_count;
      err_type            error_code;
      logic               last_result;
   } result_type;

   function automatic result_type make_result(kind_type k, logic [15:0] smp,
                                              logic [31:0] rate, logic [15:0] ch,
                                              err_type err);
      result_type r;
      r.kind          = k;
      r.sample        = smp;
      r.rate          = rate;
      r.channel_count = ch;
      r.error_code    = err;
      r.last_result   = 1'b0;
      return r;
   endfunction

endpackage

// ----- hw/rtl/wav_pcm16_chunk_parser.sv -----
// Top level: byte-serial RIFF/WAVE parser for 16-bit PCM mono files.
// The parser takes one file byte per beat and, when the result queue has room
// for two results, accepts a byte in every cycle; each byte is decoded in the
// cycle it is accepted and its zero, one or two results go into a four-entry
// result queue that drives the rsp_ port. A byte that yields two results (the
// final sample plus done, or a result plus the truncation error) writes both
// into the queue at once; sustained input rate is one byte per cycle whenever
// the consumer takes results as fast as they are made. Samples are the raw
// little-endian words in Q1.15. On an error result, discard every sample of
// that file; after done or an error, bytes are dropped until one flagged
// end_of_file, which returns the parser to its reset state.
module wav_pcm16_chunk_parser
   import wpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_sample,
   output logic [31:0]        rsp_rate,
   output logic [15:0]        rsp_channel_count,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last_result
);

   typedef enum logic [3:0] {
      PH_RIFF      = 4'd0,
      PH_RIFFSIZE  = 4'd1,
      PH_WAVE      = 4'd2,
      PH_CHUNKID   = 4'd3,
      PH_CHUNKSIZE = 4'd4,
      PH_FMTBODY   = 4'd5,
      PH_FMTEXTRA  = 4'd6,
      PH_SKIP      = 4'd7,
      PH_PAD       = 4'd8,
      PH_DATA      = 4'd9,
      PH_HALT      = 4'd10
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] remain_ff, remain_in;
   logic [15:0] fmt_code_ff, fmt_code_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [7:0]  low_ff, low_in;

   result_type             queue_ff [RESULT_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff, count_in;

   result_type  res [2];
   logic [1:0]  push_cnt;
   logic        accept, pop;
   logic [3:0]  idx_inc;
   logic [31:0] len_next, remain_dec, tag_word;
   logic [7:0]  tag_byte;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = count_ff <= CNT_W'(RESULT_DEPTH - 2);
   assign rsp_valid = count_ff != '0;

   assign idx_inc    = idx_ff + 4'd1;
   assign len_next   = len_ff | (32'(req_data_byte) << {idx_ff[1:0], 3'b000});
   assign remain_dec = remain_ff - 32'd1;
   assign tag_word   = (phase_ff == PH_RIFF) ? RIFF_ID : WAVE_ID;
   assign tag_byte   = tag_word[{~idx_ff[1:0], 3'b000} +: 8];

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      shift_in    = shift_ff;
      len_in      = len_ff;
      remain_in   = remain_ff;
      fmt_code_in = fmt_code_ff;
      chans_in    = chans_ff;
      rate_in     = rate_ff;
      align_in    = align_ff;
      bits_in     = bits_ff;
      fmt_seen_in = fmt_seen_ff;
      low_in      = low_ff;
      push_cnt    = 2'd0;
      res[0]      = make_result(KIND_SAMPLE, '0, '0, '0, ERR_BAD_ID);
      res[1]      = res[0];

      unique case (phase_ff)
         PH_RIFF, PH_WAVE: begin
            if (req_data_byte != tag_byte) begin
               res[0]   = make_result(KIND_ERROR, '0, '0, '0, ERR_BAD_ID);
               push_cnt = 2'd1;
               phase_in = PH_HALT;
            end else if (idx_ff[1:0] == 2'd3) begin
               idx_in   = '0;
               phase_in = (phase_ff == PH_RIFF) ? PH_RIFFSIZE : PH_CHUNKID;
            end else begin
               idx_in = idx_inc;
            end
         end
         PH_RIFFSIZE: begin
            if (idx_ff[1:0] == 2'd3) begin
               idx_in   = '0;
               phase_in = PH_WAVE;
            end else begin
               idx_in = idx_inc;
            end
         end
         PH_CHUNKID: begin
            shift_in = {shift_ff[23:0], req_data_byte};
            if (idx_ff[1:0] == 2'd3) begin
               idx_in   = '0;
               len_in   = '0;
               phase_in = PH_CHUNKSIZE;
            end else begin
               idx_in = idx_inc;
            end
         end
         PH_CHUNKSIZE: begin
            len_in = len_next;
            if (idx_ff[1:0] != 2'd3) begin
               idx_in = idx_inc;
            end else begin
               idx_in = '0;
               if (shift_ff == FMT_ID) begin
                  if (len_next < FMT_BODY_LEN) begin
                     res[0]   = make_result(KIND_ERROR, '0, '0, '0, ERR_FMT_SMALL);
                     push_cnt = 2'd1;
                     phase_in = PH_HALT;
                  end else begin
                     remain_in = len_next - FMT_BODY_LEN;
                     phase_in  = PH_FMTBODY;
                  end
               end else if (shift_ff == DATA_ID) begin
                  if (!fmt_seen_ff) begin
                     res[0]   = make_result(KIND_ERROR, '0, '0, '0, ERR_NO_FMT);
                     push_cnt = 2'd1;
                     phase_in = PH_HALT;
                  end else if (fmt_code_ff != PCM_FORMAT || chans_ff != MONO ||
                               bits_ff != PCM_BITS || align_ff == '0) begin
                     res[0]   = make_result(KIND_ERROR, '0, '0, '0, ERR_UNSUPPORTED);
                     push_cnt = 2'd1;
                     phase_in = PH_HALT;
                  end else if (len_next[0]) begin
                     res[0]   = make_result(KIND_ERROR, '0, '0, '0, ERR_ODD_DATA);
                     push_cnt = 2'd1;
                     phase_in = PH_HALT;
                  end else begin
                     remain_in = len_next;
                     if (len_next == '0) begin
                        res[0]   = make_result(KIND_DONE, '0, rate_ff, chans_ff,
                                               ERR_BAD_ID);
                        push_cnt = 2'd1;
                        phase_in = PH_HALT;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end else begin
                  remain_in = len_next;
                  if (len_next == '0) begin
                     phase_in = len_next[0] ? PH_PAD : PH_CHUNKID;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
         end
         PH_FMTBODY: begin
            case (idx_ff)
               4'd0, 4'd1:
                  fmt_code_in[{idx_ff[0], 3'b000} +: 8] = req_data_byte;
               4'd2, 4'd3:
                  chans_in[{idx_ff[0], 3'b000} +: 8] = req_data_byte;
               4'd4, 4'd5, 4'd6, 4'd7:
                  rate_in[{idx_ff[1:0], 3'b000} +: 8] = req_data_byte;
               4'd12, 4'd13:
                  align_in[{idx_ff[0], 3'b000} +: 8] = req_data_byte;
               4'd14, 4'd15:
                  bits_in[{idx_ff[0], 3'b000} +: 8] = req_data_byte;
               default: ;
            endcase
            if (idx_ff == 4'd15) begin
               idx_in = '0;
               if (remain_ff != '0) begin
                  phase_in = PH_FMTEXTRA;
               end else begin
                  fmt_seen_in = 1'b1;
                  phase_in    = len_ff[0] ? PH_PAD : PH_CHUNKID;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         PH_FMTEXTRA: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               fmt_seen_in = 1'b1;
               idx_in      = '0;
               phase_in    = len_ff[0] ? PH_PAD : PH_CHUNKID;
            end
         end
         PH_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               idx_in   = '0;
               phase_in = len_ff[0] ? PH_PAD : PH_CHUNKID;
            end
         end
         PH_PAD: begin
            idx_in   = '0;
            phase_in = PH_CHUNKID;
         end
         PH_DATA: begin
            if (!idx_ff[0]) begin
               low_in = req_data_byte;
               idx_in = 4'd1;
            end else begin
               res[0]   = make_result(KIND_SAMPLE, {req_data_byte, low_ff}, '0, '0,
                                      ERR_BAD_ID);
               push_cnt = 2'd1;
               idx_in   = '0;
            end
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               res[push_cnt[0]] = make_result(KIND_DONE, '0, rate_ff, chans_ff,
                                              ERR_BAD_ID);
               push_cnt = push_cnt + 2'd1;
               phase_in = PH_HALT;
            end
         end
         default: ;
      endcase

      if (req_end_of_file) begin
         if (phase_in != PH_HALT && phase_in <= PH_DATA) begin
            res[push_cnt[0]] = make_result(KIND_ERROR, '0, '0, '0, ERR_TRUNCATED);
            push_cnt = push_cnt + 2'd1;
         end
         phase_in    = PH_RIFF;
         idx_in      = '0;
         shift_in    = '0;
         len_in      = '0;
         remain_in   = '0;
         fmt_code_in = '0;
         chans_in    = '0;
         rate_in     = '0;
         align_in    = '0;
         bits_in     = '0;
         fmt_seen_in = 1'b0;
         low_in      = '0;
      end

      if (push_cnt == 2'd2) begin
         res[1].last_result = 1'b1;
      end else if (push_cnt == 2'd1) begin
         res[0].last_result = 1'b1;
      end

      if (!accept) begin
         push_cnt = 2'd0;
      end

      count_in = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         idx_ff      <= '0;
         shift_ff    <= '0;
         len_ff      <= '0;
         remain_ff   <= '0;
         fmt_code_ff <= '0;
         chans_ff    <= '0;
         rate_ff     <= '0;
         align_ff    <= '0;
         bits_ff     <= '0;
         fmt_seen_ff <= 1'b0;
         low_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            idx_ff      <= idx_in;
            shift_ff    <= shift_in;
            len_ff      <= len_in;
            remain_ff   <= remain_in;
            fmt_code_ff <= fmt_code_in;
            chans_ff    <= chans_in;
            rate_ff     <= rate_in;
            align_ff    <= align_in;
            bits_ff     <= bits_in;
            fmt_seen_ff <= fmt_seen_in;
            low_ff      <= low_in;
         end
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res[0];
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res[1];
      end
   end

   assign rsp_kind          = queue_ff[rd_ptr_ff].kind;
   assign rsp_sample        = queue_ff[rd_ptr_ff].sample;
   assign rsp_rate          = queue_ff[rd_ptr_ff].rate;
   assign rsp_channel_count = queue_ff[rd_ptr_ff].channel_count;
   assign rsp_error_code    = queue_ff[rd_ptr_ff].error_code;
   assign rsp_last_result   = queue_ff[rd_ptr_ff].last_result;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RESULT_DEPTH))
      else $error("result queue overflow");

   a_eof_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_file |=> phase_ff == PH_RIFF && !fmt_seen_ff)
      else $error("end-of-file beat did not re-arm parser");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_HALT && !req_end_of_file
      |=> count_ff <= $past(count_ff))
      else $error("halted parser produced a result");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: streams byte-wise WAV files into the parser and checks each result beat.
`timescale 1ns / 1ps

module tb_top;
   import wpc_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef enum logic [3:0] {
      ST_RIFF, ST_RIFF_LEN, ST_WAVE, ST_CHUNK_ID, ST_CHUNK_LEN, ST_FMT_BODY,
      ST_FMT_EXTRA, ST_SKIP, ST_PAD, ST_DATA, ST_HALT
   } parse_state_type;

   typedef struct {
      logic [7:0]  data;
      logic        eof;
      int unsigned gap_pct;
      int unsigned stall_pct;
      bit          drain;
   } wav_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_end_of_file = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [15:0] rsp_sample;
   logic [31:0]        rsp_rate;
   logic [15:0]        rsp_channel_count;
   logic [2:0]         rsp_error_code;
   logic               rsp_last_result;

   wav_byte_type wav_bytes[$];
   logic [7:0]  file_buf[$];
   result_type  due_results[$];
   result_type  step_results[$];
   int unsigned stall_pct = 0;
   int unsigned fail_count = 0;
   int unsigned byte_total = 0;
   int unsigned quiet_cycles = 0;
   int unsigned gap_mix[4]   = '{0, 88, 0, 27};
   int unsigned stall_mix[4] = '{0, 0, 88, 27};

   // parser state as seen by the predictor
   parse_state_type ph;
   int unsigned  pos;
   logic [31:0]  id_shift, chunk_len, remaining, fmt_rate;
   logic [15:0]  fmt_code, fmt_chans, fmt_align, fmt_bits;
   logic         fmt_seen;
   logic [7:0]   low_byte;

   wav_pcm16_chunk_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_sample        (rsp_sample),
      .rsp_rate          (rsp_rate),
      .rsp_channel_count (rsp_channel_count),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic void reset_parser();
      ph        = ST_RIFF;
      pos       = 0;
      id_shift  = '0;
      chunk_len = '0;
      remaining = '0;
      fmt_rate  = '0;
      fmt_code  = '0;
      fmt_chans = '0;
      fmt_align = '0;
      fmt_bits  = '0;
      fmt_seen  = 1'b0;
      low_byte  = '0;
   endfunction

   function automatic void add_sample(logic [15:0] s);
      result_type r;
      r = '0;
      r.kind   = KIND_SAMPLE;
      r.sample = s;
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic void report_done();
      result_type r;
      r = '0;
      r.kind          = KIND_DONE;
      r.rate          = fmt_rate;
      r.channel_count = fmt_chans;
      step_results.insert(step_results.size(), r);
      ph = ST_HALT;
   endfunction

   function automatic void raise_error(err_type code);
      result_type r;
      r = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      step_results.insert(step_results.size(), r);
      ph = ST_HALT;
   endfunction

   function automatic void close_chunk();
      pos = 0;
      ph  = chunk_len[0] ? ST_PAD : ST_CHUNK_ID;
   endfunction

   function automatic void open_chunk();
      pos = 0;
      if (id_shift == FMT_ID) begin
         if (chunk_len < FMT_BODY_LEN) begin
            raise_error(ERR_FMT_SMALL);
         end else begin
            remaining = chunk_len - FMT_BODY_LEN;
            ph = ST_FMT_BODY;
         end
      end else if (id_shift == DATA_ID) begin
         if (!fmt_seen) begin
            raise_error(ERR_NO_FMT);
         end else if (fmt_code != PCM_FORMAT || fmt_chans != MONO || fmt_bits != PCM_BITS ||
                      fmt_align == 16'd0) begin
            raise_error(ERR_UNSUPPORTED);
         end else if (chunk_len[0]) begin
            raise_error(ERR_ODD_DATA);
         end else begin
            remaining = chunk_len;
            if (remaining == 0) report_done();
            else ph = ST_DATA;
         end
      end else begin
         remaining = chunk_len;
         if (remaining == 0) close_chunk();
         else ph = ST_SKIP;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic eof);
      logic [31:0] tag;
      step_results.delete();
      case (ph)
         ST_RIFF, ST_WAVE: begin
            tag = (ph == ST_RIFF) ? RIFF_ID : WAVE_ID;
            if (b != tag[8*(3-pos) +: 8]) begin
               raise_error(ERR_BAD_ID);
            end else if (pos == 3) begin
               pos = 0;
               ph  = (ph == ST_RIFF) ? ST_RIFF_LEN : ST_CHUNK_ID;
            end else begin
               pos++;
            end
         end
         ST_RIFF_LEN: begin
            if (pos == 3) begin
               pos = 0;
               ph  = ST_WAVE;
            end else begin
               pos++;
            end
         end
         ST_CHUNK_ID: begin
            id_shift = {id_shift[23:0], b};
            if (pos == 3) begin
               pos = 0;
               chunk_len = '0;
               ph = ST_CHUNK_LEN;
            end else begin
               pos++;
            end
         end
         ST_CHUNK_LEN: begin
            chunk_len[8*pos +: 8] = b;
            if (pos == 3) open_chunk();
            else pos++;
         end
         ST_FMT_BODY: begin
            if (pos < 2) fmt_code[8*pos +: 8] = b;
            else if (pos < 4) fmt_chans[8*(pos-2) +: 8] = b;
            else if (pos < 8) fmt_rate[8*(pos-4) +: 8] = b;
            else if (pos >= 12 && pos < 14) fmt_align[8*(pos-12) +: 8] = b;
            else if (pos >= 14) fmt_bits[8*(pos-14) +: 8] = b;
            if (pos == 15) begin
               pos = 0;
               if (remaining != 0) begin
                  ph = ST_FMT_EXTRA;
               end else begin
                  fmt_seen = 1'b1;
                  close_chunk();
               end
            end else begin
               pos++;
            end
         end
         ST_FMT_EXTRA: begin
            remaining--;
            if (remaining == 0) begin
               fmt_seen = 1'b1;
               close_chunk();
            end
         end
         ST_SKIP: begin
            remaining--;
            if (remaining == 0) close_chunk();
         end
         ST_PAD: begin
            pos = 0;
            ph  = ST_CHUNK_ID;
         end
         ST_DATA: begin
            if (pos % 2 == 0) begin
               low_byte = b;
               pos = 1;
            end else begin
               add_sample({b, low_byte});
               pos = 0;
            end
            remaining--;
            if (remaining == 0) report_done();
         end
         default: ;
      endcase
      if (eof) begin
         if (ph != ST_HALT) raise_error(ERR_TRUNCATED);
         reset_parser();
      end
      if (step_results.size() != 0) begin
         step_results[step_results.size()-1].last_result = 1'b1;
         foreach (step_results[i]) due_results.insert(due_results.size(), step_results[i]);
      end
   endfunction

   // ---------------- file builders ----------------

   function automatic void put8(logic [7:0] b);
      file_buf.insert(file_buf.size(), b);
   endfunction

   function automatic void put16(logic [15:0] v);
      put8(v[7:0]);
      put8(v[15:8]);
   endfunction

   function automatic void put32(logic [31:0] v);
      put16(v[15:0]);
      put16(v[31:16]);
   endfunction

   function automatic void put_tag(logic [31:0] id);
      put8(id[31:24]);
      put8(id[23:16]);
      put8(id[15:8]);
      put8(id[7:0]);
   endfunction

   function automatic void put_header();
      put_tag(RIFF_ID);
      put32($urandom);
      put_tag(WAVE_ID);
   endfunction

   function automatic void put_chunk(logic [31:0] id, int unsigned len);
      put_tag(id);
      put32(len);
      repeat (len + len % 2) put8(8'($urandom));
   endfunction

   function automatic void put_fmt(int unsigned len, logic [15:0] code, logic [15:0] chans,
                                   logic [31:0] rate, logic [15:0] align, logic [15:0] bw);
      put_tag(FMT_ID);
      put32(len);
      put16(code);
      put16(chans);
      put32(rate);
      put32($urandom);
      put16(align);
      put16(bw);
      repeat (len - 16 + len % 2) put8(8'($urandom));
   endfunction

   function automatic void put_samples(int unsigned n);
      logic [15:0] s;
      repeat (n / 2) begin
         case ($urandom_range(7))
            0:       s = 16'h8000;
            1:       s = 16'h7FFF;
            2:       s = 16'h0000;
            3:       s = 16'hFFFF;
            default: s = 16'($urandom);
         endcase
         put16(s);
      end
      if (n % 2) put8(8'($urandom));
   endfunction

   function automatic logic [31:0] other_id();
      logic [31:0] id;
      do id = $urandom; while (id == FMT_ID || id == DATA_ID);
      return id;
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(3))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_file(int unsigned file_no);
      wav_byte_type w;
      int unsigned mix;
      mix = (file_no / 3) % 4;
      foreach (file_buf[i]) begin
         w.data      = file_buf[i];
         w.eof       = (i == file_buf.size() - 1);
         w.gap_pct   = gap_mix[mix];
         w.stall_pct = stall_mix[mix];
         w.drain     = (i == 0) && (file_no % 6 == 0);
         wav_bytes.insert(wav_bytes.size(), w);
      end
      byte_total += file_buf.size();
      file_buf.delete();
   endfunction

   function automatic void random_file(int unsigned file_no);
      int unsigned shape, n, cut;
      logic [15:0] code, chans, bw, al;
      shape = $urandom_range(99);
      if (shape < 5) begin
         repeat ($urandom_range(1, 12)) put8(8'($urandom));
      end else begin
         put_header();
         repeat ($urandom_range(0, 2)) put_chunk(other_id(), $urandom_range(0, 9));
         code  = PCM_FORMAT;
         chans = MONO;
         bw    = PCM_BITS;
         al    = ($urandom_range(1)) ? 16'd2 : 16'($urandom_range(1, 65535));
         if (shape >= 13 && shape < 25) begin
            case ($urandom_range(3))
               0: code  = ($urandom_range(1)) ? 16'd0 : 16'($urandom_range(2, 65535));
               1: chans = ($urandom_range(1)) ? 16'd0 : 16'($urandom_range(2, 65535));
               2: bw    = ($urandom_range(1)) ? 16'd8 : 16'($urandom_range(17, 65535));
               default: al = 16'd0;
            endcase
         end
         if (shape >= 30 && shape < 38)
            put_fmt(16, PCM_FORMAT, 16'd2, pick_rate(), 16'd4, PCM_BITS);
         if (shape < 10) put_chunk(DATA_ID, 2 * $urandom_range(0, 4));
         else if (shape < 13) put_chunk(FMT_ID, $urandom_range(0, 15));
         else put_fmt($urandom_range(16, 22), code, chans, pick_rate(), al, bw);
         if ($urandom_range(3) == 0) put_chunk(other_id(), $urandom_range(0, 7));
         n = 2 * $urandom_range(0, 20);
         if (shape >= 25 && shape < 30) n++;
         put_tag(DATA_ID);
         put32(n);
         put_samples(n);
         repeat ($urandom_range(0, 3)) put8(8'($urandom));
         if (shape >= 80 && shape < 90) begin
            cut = $urandom_range(file_buf.size() - 1);
            file_buf[cut] = file_buf[cut] ^ 8'($urandom_range(1, 255));
         end else if (shape >= 90) begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut) void'(file_buf.pop_back());
         end
      end
      queue_file(file_no);
   endfunction

   // ---------------- driver ----------------

   always @(posedge clock) begin : drive_bytes
      wav_byte_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (wav_bytes.size() != 0 &&
             (!wav_bytes[0].drain || (!req_valid && !rsp_valid && due_results.size() == 0)) &&
             $urandom_range(99) >= wav_bytes[0].gap_pct) begin
            w = wav_bytes.pop_front();
            req_valid       <= 1'b1;
            req_data_byte   <= w.data;
            req_end_of_file <= w.eof;
            stall_pct       <= w.stall_pct;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin : watch_results
      result_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet_cycles = 0;
         reset_parser();
         due_results.delete();
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (req_valid && req_ready) parse_byte(req_data_byte, req_end_of_file);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_sample, rsp_rate, rsp_channel_count, rsp_error_code,
                   rsp_last_result};
            if (due_results.size() == 0) begin
               note_mismatch("unexpected beat kind", 32'hFFFF_FFFF, 32'(got.kind));
            end else begin
               want = due_results.pop_front();
               if (got.kind !== want.kind)
                  note_mismatch("kind", 32'(want.kind), 32'(got.kind));
               if (got.sample !== want.sample)
                  note_mismatch("sample", 32'(want.sample), 32'(got.sample));
               if (got.rate !== want.rate)
                  note_mismatch("rate", want.rate, got.rate);
               if (got.channel_count !== want.channel_count)
                  note_mismatch("channel_count", 32'(want.channel_count),
                                32'(got.channel_count));
               if (got.error_code !== want.error_code)
                  note_mismatch("error_code", 32'(want.error_code), 32'(got.error_code));
               if (got.last_result !== want.last_result)
                  note_mismatch("last_result", 32'(want.last_result), 32'(got.last_result));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------- stimulus and end of run ----------------

   initial begin
      int unsigned file_no;
      file_no = 0;

      // full file, extreme samples and rate, eof on the final sample byte
      put_header();
      put_fmt(16, PCM_FORMAT, MONO, 32'hFFFF_FFFF, 16'd2, PCM_BITS);
      put_tag(DATA_ID);
      put32(8);
      put16(16'h8000);
      put16(16'h7FFF);
      put16(16'h0000);
      put16(16'hFFFF);
      queue_file(file_no++);

      // odd unknown chunk plus pad, fmt with extra bytes, empty chunk, empty data
      put_header();
      put_chunk(other_id(), 3);
      put_fmt(19, PCM_FORMAT, MONO, 32'd0, 16'hFFFF, PCM_BITS);
      put_chunk(other_id(), 0);
      put_tag(DATA_ID);
      put32(0);
      repeat (3) put8(8'($urandom));
      queue_file(file_no++);

      // second fmt overrides a stereo one
      put_header();
      put_fmt(16, PCM_FORMAT, 16'd2, 32'd8000, 16'd4, PCM_BITS);
      put_fmt(16, PCM_FORMAT, MONO, 32'd44100, 16'd2, PCM_BITS);
      put_tag(DATA_ID);
      put32(4);
      put_samples(4);
      put8(8'hA5);
      queue_file(file_no++);

      // bad RIFF id at the second byte
      put8(RIFF_ID[31:24]);
      put8(8'h58);
      repeat (5) put8(8'($urandom));
      queue_file(file_no++);

      // bad WAVE id at its last byte
      put_tag(RIFF_ID);
      put32($urandom);
      put_tag({WAVE_ID[31:8], 8'h58});
      put8(8'h00);
      queue_file(file_no++);

      // fmt body too short
      put_header();
      put_chunk(FMT_ID, 15);
      queue_file(file_no++);

      // data ahead of fmt
      put_header();
      put_chunk(DATA_ID, 4);
      queue_file(file_no++);

      // unsupported formats: code, channels, bits, zero alignment
      put_header();
      put_fmt(16, 16'd3, MONO, 32'd48000, 16'd2, PCM_BITS);
      put_chunk(DATA_ID, 4);
      queue_file(file_no++);
      put_header();
      put_fmt(16, PCM_FORMAT, 16'd2, 32'd48000, 16'd2, PCM_BITS);
      put_chunk(DATA_ID, 4);
      queue_file(file_no++);
      put_header();
      put_fmt(16, PCM_FORMAT, MONO, 32'd48000, 16'd2, 16'd8);
      put_chunk(DATA_ID, 4);
      queue_file(file_no++);
      put_header();
      put_fmt(16, PCM_FORMAT, MONO, 32'd48000, 16'd0, PCM_BITS);
      put_chunk(DATA_ID, 4);
      queue_file(file_no++);

      // odd data size
      put_header();
      put_fmt(16, PCM_FORMAT, MONO, 32'd22050, 16'd2, PCM_BITS);
      put_chunk(DATA_ID, 5);
      queue_file(file_no++);

      // early end on a byte that completes a sample
      put_header();
      put_fmt(16, PCM_FORMAT, MONO, 32'd16000, 16'd2, PCM_BITS);
      put_tag(DATA_ID);
      put32(8);
      put_samples(4);
      queue_file(file_no++);

      // early end on a low sample byte
      put_header();
      put_fmt(16, PCM_FORMAT, MONO, 32'd16000, 16'd2, PCM_BITS);
      put_tag(DATA_ID);
      put32(8);
      put_samples(3);
      queue_file(file_no++);

      // one-byte files: matching first id byte, then a mismatching one
      put8(RIFF_ID[31:24]);
      queue_file(file_no++);
      put8(8'h00);
      queue_file(file_no++);

      while (byte_total < 1950) random_file(file_no++);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (wav_bytes.size() != 0 || req_valid || due_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (due_results.size() != 0) begin
         fail_count++;
         $display("%0t: %0d results outstanding, expected kind %0d, actual none", $time,
                  due_results.size(), due_results[0].kind);
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
